>>> sv/swma_pkg.sv
package swma_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int WINDOW_MAX  = 256;
    localparam int ADDR_BITS   = $clog2(WINDOW_MAX);
    localparam int LEN_BITS    = ADDR_BITS + 1;
    localparam int SUM_BITS    = SAMPLE_BITS + ADDR_BITS + 1;
    localparam int OUT_BITS    = 24;
    localparam int FRAC_BITS   = 8;
    localparam int DIV_BITS    = SUM_BITS + FRAC_BITS;
    localparam int CNT_BITS    = $clog2(DIV_BITS);
    localparam int REM_BITS    = LEN_BITS + 1;
    localparam int PADDR_BITS  = 3;

    // Register index as decoded from paddr[2]
    localparam logic REG_WINDOW_LEN = 1'b0;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } in_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] max_window_sum;
        logic signed [OUT_BITS-1:0] max_average;
        logic                       too_short;
    } out_t;

    // Window result handed to the divider on the last sample
    typedef struct packed {
        logic                       start;
        logic                       seen;
        logic signed [SUM_BITS-1:0] best;
    } result_req_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_FIN,
        DIV_OUT
    } div_state_t;

    function automatic logic signed [OUT_BITS-1:0] sat_out(
        input logic signed [DIV_BITS:0] v
    );
        logic signed [DIV_BITS:0] hi;
        logic signed [DIV_BITS:0] lo;
        hi = (DIV_BITS+1)'((64'sd1 <<< (OUT_BITS-1)) - 64'sd1);
        lo = -(DIV_BITS+1)'(64'sd1 <<< (OUT_BITS-1));
        if (v > hi) begin
            return hi[OUT_BITS-1:0];
        end else if (v < lo) begin
            return lo[OUT_BITS-1:0];
        end else begin
            return v[OUT_BITS-1:0];
        end
    endfunction

endpackage

>>> sv/sliding_window_max_average_unit.sv
// Sliding-window maximum sum and maximum mean. Samples stream in on s_ one per
// cycle; window_len (register 0, 1..256, 0 acts as 1, above 256 as 256) sets
// the window. The last samples of the window sit in a 256-entry ring RAM read
// in the cycle before the running-sum update, with forwarding for back-to-back
// writes to the same slot. On the sample flagged last_sample, one result goes
// out on m_: the largest full-window sum and the largest mean in signed Q.8,
// truncated toward zero, both saturated to 24 bits, or too_short with zero
// fields when no full window was seen. The mean comes from a one-bit-per-cycle
// divider, so after a last sample the input holds off until the divider is done
// and m_ready has taken the result. Writing window_len drops the sequence in
// progress. No clearing pass is needed after reset.
module sliding_window_max_average_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [swma_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  swma_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output swma_pkg::out_t                  m_data
);

    localparam int LW = swma_pkg::LEN_BITS;

    logic [LW-1:0]         window_len_reg;
    logic [LW-1:0]         eff_len;
    logic                  cfg_write;
    logic                  cfg_clear;
    logic                  done;
    swma_pkg::result_req_t req;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_clear = cfg_write && (paddr[2] == swma_pkg::REG_WINDOW_LEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= LW'(1);
        end else if (cfg_clear) begin
            window_len_reg <= pwdata[LW-1:0];
        end
    end

    always_comb begin
        priority if (window_len_reg == '0) begin
            eff_len = LW'(1);
        end else if (window_len_reg > LW'(swma_pkg::WINDOW_MAX)) begin
            eff_len = LW'(swma_pkg::WINDOW_MAX);
        end else begin
            eff_len = window_len_reg;
        end
    end

    assign prdata = (paddr[2] == swma_pkg::REG_WINDOW_LEN) ? 32'(window_len_reg) : 32'd0;

    swma_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (cfg_clear),
        .win_len (eff_len),
        .in_valid(s_valid),
        .in_ready(s_ready),
        .in_data (s_data),
        .done    (done),
        .req     (req)
    );

    swma_div u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .clear  (cfg_clear),
        .win_len(eff_len),
        .req    (req),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data),
        .done   (done)
    );

endmodule

>>> sv/swma_ram.sv
module swma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/swma_window.sv
module swma_window (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              clear,
    input  logic [swma_pkg::LEN_BITS-1:0]     win_len,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  swma_pkg::in_t                     in_data,
    input  logic                              done,
    output swma_pkg::result_req_t             req
);

    localparam int AW = swma_pkg::ADDR_BITS;
    localparam int LW = swma_pkg::LEN_BITS;
    localparam int SW = swma_pkg::SUM_BITS;
    localparam int DW = swma_pkg::SAMPLE_BITS;

    logic          accept;
    logic          busy_reg, busy_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [LW-1:0] fill_reg, fill_next;
    logic [LW-1:0] fill_after;
    logic [LW-1:0] slot_inc;
    logic          full_now;

    logic                 s2_valid_reg;
    logic signed [DW-1:0] s2_sample_reg;
    logic                 s2_last_reg;
    logic                 s2_sub_reg;
    logic                 s2_full_reg;
    logic [AW-1:0]        s2_addr_reg;
    logic                 fwd_hit_reg;
    logic signed [DW-1:0] fwd_data_reg;

    logic signed [SW-1:0] sum_reg, sum_next;
    logic signed [SW-1:0] best_reg, best_next;
    logic                 seen_reg, seen_next;
    logic signed [SW-1:0] sum_upd;
    logic signed [SW-1:0] best_upd;
    logic                 seen_upd;
    logic signed [DW-1:0] old_sample;
    logic [DW-1:0]        ram_rdata;

    assign in_ready = !busy_reg;
    assign accept   = in_valid && in_ready;

    // Front stage: ring bookkeeping, settled at accept
    assign full_now   = (fill_reg >= win_len);
    assign fill_after = full_now ? fill_reg : fill_reg + LW'(1);
    assign slot_inc   = {1'b0, slot_reg} + LW'(1);

    always_comb begin
        slot_next = slot_reg;
        fill_next = fill_reg;
        busy_next = busy_reg;
        if (accept) begin
            if (in_data.last_sample) begin
                slot_next = '0;
                fill_next = '0;
                busy_next = 1'b1;
            end else begin
                slot_next = (slot_inc >= win_len) ? '0 : slot_inc[AW-1:0];
                fill_next = fill_after;
            end
        end
        if (done) begin
            busy_next = 1'b0;
        end
        if (clear) begin
            slot_next = '0;
            fill_next = '0;
            busy_next = 1'b0;
        end
    end

    swma_ram #(
        .WIDTH(DW),
        .DEPTH(swma_pkg::WINDOW_MAX)
    ) u_ring (
        .aclk (aclk),
        .we   (s2_valid_reg),
        .waddr(s2_addr_reg),
        .wdata(s2_sample_reg),
        .raddr(slot_reg),
        .rdata(ram_rdata)
    );

    // Back stage: update sums; forward the sample if it was written as it was read
    assign old_sample = fwd_hit_reg ? fwd_data_reg : $signed(ram_rdata);
    assign sum_upd = sum_reg
                   - (s2_sub_reg ? SW'(old_sample) : SW'(0))
                   + SW'(s2_sample_reg);
    assign best_upd = (s2_full_reg && (!seen_reg || sum_upd > best_reg)) ? sum_upd : best_reg;
    assign seen_upd = seen_reg || s2_full_reg;

    always_comb begin
        sum_next  = sum_reg;
        best_next = best_reg;
        seen_next = seen_reg;
        req       = '0;
        if (s2_valid_reg) begin
            if (s2_last_reg) begin
                req.start = 1'b1;
                req.seen  = seen_upd;
                req.best  = best_upd;
                sum_next  = '0;
                best_next = '0;
                seen_next = 1'b0;
            end else begin
                sum_next  = sum_upd;
                best_next = best_upd;
                seen_next = seen_upd;
            end
        end
        if (clear) begin
            sum_next  = '0;
            best_next = '0;
            seen_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            slot_reg     <= '0;
            fill_reg     <= '0;
            s2_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            sum_reg      <= '0;
            best_reg     <= '0;
            seen_reg     <= 1'b0;
        end else begin
            busy_reg     <= busy_next;
            slot_reg     <= slot_next;
            fill_reg     <= fill_next;
            s2_valid_reg <= accept && !clear;
            fwd_hit_reg  <= accept && s2_valid_reg && (s2_addr_reg == slot_reg);
            sum_reg      <= sum_next;
            best_reg     <= best_next;
            seen_reg     <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= s2_sample_reg;
        if (accept) begin
            s2_sample_reg <= in_data.sample;
            s2_last_reg   <= in_data.last_sample;
            s2_sub_reg    <= full_now;
            s2_full_reg   <= (fill_after >= win_len);
            s2_addr_reg   <= slot_reg;
        end
    end

endmodule

>>> sv/swma_div.sv
module swma_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          clear,
    input  logic [swma_pkg::LEN_BITS-1:0] win_len,
    input  swma_pkg::result_req_t         req,
    output logic                          m_valid,
    input  logic                          m_ready,
    output swma_pkg::out_t                m_data,
    output logic                          done
);

    localparam int SW = swma_pkg::SUM_BITS;
    localparam int NW = swma_pkg::DIV_BITS;
    localparam int CW = swma_pkg::CNT_BITS;
    localparam int RW = swma_pkg::REM_BITS;

    swma_pkg::div_state_t state_reg, state_next;

    logic [CW-1:0]        cnt_reg;
    logic [NW-1:0]        num_reg;
    logic [RW-1:0]        rem_reg;
    logic                 neg_reg;
    logic signed [SW-1:0] best_reg;
    swma_pkg::out_t       out_reg;

    logic [RW-1:0]        rem_try;
    logic                 q_bit;
    logic [SW-1:0]        mag;
    logic signed [NW:0]   avg_signed;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            swma_pkg::DIV_IDLE: begin
                if (req.start) begin
                    state_next = req.seen ? swma_pkg::DIV_RUN : swma_pkg::DIV_OUT;
                end
            end
            swma_pkg::DIV_RUN: begin
                if (cnt_reg == CW'(NW - 1)) begin
                    state_next = swma_pkg::DIV_FIN;
                end
            end
            swma_pkg::DIV_FIN: begin
                state_next = swma_pkg::DIV_OUT;
            end
            swma_pkg::DIV_OUT: begin
                if (m_ready) begin
                    state_next = swma_pkg::DIV_IDLE;
                end
            end
            default: begin
                state_next = swma_pkg::DIV_IDLE;
            end
        endcase
        if (clear) begin
            state_next = swma_pkg::DIV_IDLE;
        end
    end

    always_comb begin
        m_valid = (state_reg == swma_pkg::DIV_OUT);
        done    = (state_reg == swma_pkg::DIV_OUT) && m_ready;
    end

    // One quotient bit per cycle, magnitude restoring division
    assign rem_try = {rem_reg[RW-2:0], num_reg[NW-1]};
    assign q_bit   = (rem_try >= RW'(win_len));
    assign mag     = req.best[SW-1] ? SW'(-req.best) : SW'(req.best);
    assign avg_signed = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= swma_pkg::DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            swma_pkg::DIV_IDLE: begin
                cnt_reg  <= '0;
                rem_reg  <= '0;
                neg_reg  <= req.best[SW-1];
                best_reg <= req.best;
                num_reg  <= {mag, {swma_pkg::FRAC_BITS{1'b0}}};
                if (req.start && !req.seen) begin
                    out_reg.max_window_sum <= '0;
                    out_reg.max_average    <= '0;
                    out_reg.too_short      <= 1'b1;
                end
            end
            swma_pkg::DIV_RUN: begin
                cnt_reg <= cnt_reg + CW'(1);
                rem_reg <= q_bit ? rem_try - RW'(win_len) : rem_try;
                num_reg <= {num_reg[NW-2:0], q_bit};
            end
            swma_pkg::DIV_FIN: begin
                out_reg.max_window_sum <= swma_pkg::sat_out((NW+1)'(best_reg));
                out_reg.max_average    <= swma_pkg::sat_out(avg_signed);
                out_reg.too_short      <= 1'b0;
            end
            swma_pkg::DIV_OUT: begin
                cnt_reg <= '0;
            end
            default: begin
                cnt_reg <= '0;
            end
        endcase
    end

    assign m_data = out_reg;

endmodule

>>> verif/sliding_window_max_average_unit_test.sv
`timescale 1ns / 100ps

module sliding_window_max_average_unit_test;

    import swma_pkg::*;

    localparam logic [PADDR_BITS-1:0] LEN_ADDR   = {REG_WINDOW_LEN, 2'b00};
    localparam logic [PADDR_BITS-1:0] SPARE_ADDR = {~REG_WINDOW_LEN, 2'b00};
    localparam int     TOTAL_ITEMS  = 720;
    localparam int     DRAIN_CYCLES = 60;
    localparam int     MAX_GAP      = 11;
    localparam longint OUT_HI       = (64'sd1 <<< (OUT_BITS - 1)) - 64'sd1;
    localparam longint OUT_LO       = -(64'sd1 <<< (OUT_BITS - 1));

    localparam int TONE_MIXED = 0;
    localparam int TONE_HIGH  = 1;
    localparam int TONE_LOW   = 2;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [PADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_t         s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_t        m_data;

    // window length register and running window state
    logic [8:0]  cfg_len;
    longint      sample_hist [WINDOW_MAX];
    int unsigned next_slot;
    int unsigned fill;
    longint      window_sum;
    longint      peak_sum;
    bit          have_window;

    in_t  sample_queue [$];
    out_t window_results [$];
    int   queued_count = 0;
    int   taken_count  = 0;
    int   error_count  = 0;
    int   send_gap     = 0;
    int   hold_cycles  = 0;
    bit   send_lazy    = 1'b0;
    bit   recv_lazy    = 1'b0;

    sliding_window_max_average_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int unsigned span();
        if (cfg_len == 0) begin
            return 1;
        end
        if (cfg_len > WINDOW_MAX) begin
            return WINDOW_MAX;
        end
        return cfg_len;
    endfunction

    function automatic void clear_run();
        next_slot   = 0;
        fill        = 0;
        window_sum  = 0;
        peak_sum    = 0;
        have_window = 1'b0;
    endfunction

    function automatic logic signed [OUT_BITS-1:0] clip_out(longint v);
        if (v > OUT_HI) begin
            v = OUT_HI;
        end
        if (v < OUT_LO) begin
            v = OUT_LO;
        end
        return v[OUT_BITS-1:0];
    endfunction

    // advance the window state by one sample; queue the summary on the last one
    function automatic void track_sample(in_t item);
        int unsigned len;
        int unsigned slot;
        longint      value;
        out_t        summary;
        len   = span();
        value = longint'($signed(item.sample));
        slot  = next_slot % WINDOW_MAX;
        if (fill >= len) begin
            window_sum -= sample_hist[slot];
        end else begin
            fill++;
        end
        window_sum += value;
        sample_hist[slot] = value;
        next_slot = (slot + 1 >= len) ? 0 : slot + 1;
        if (fill >= len) begin
            if (!have_window || window_sum > peak_sum) begin
                peak_sum = window_sum;
            end
            have_window = 1'b1;
        end
        if (item.last_sample) begin
            if (have_window) begin
                summary.max_window_sum = clip_out(peak_sum);
                summary.max_average    = clip_out((peak_sum * 256) / longint'(len));
                summary.too_short      = 1'b0;
            end else begin
                summary = '0;
                summary.too_short = 1'b1;
            end
            window_results = {window_results, summary};
            clear_run();
        end
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(int tone);
        int unsigned pick;
        if (tone == TONE_HIGH) begin
            return 16'sh7FFF;
        end
        if (tone == TONE_LOW) begin
            return 16'sh8000;
        end
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            return 16'sh7FFF;
        end else if (pick == 1) begin
            return 16'sh8000;
        end else if (pick < 4) begin
            return SAMPLE_BITS'($urandom_range(0, 200) - 100);
        end
        return SAMPLE_BITS'($urandom_range(0, 65535));
    endfunction

    task automatic push_sample(logic signed [SAMPLE_BITS-1:0] value, bit last);
        in_t item;
        item.sample      = value;
        item.last_sample = last;
        sample_queue = {sample_queue, item};
        queued_count++;
    endtask

    task automatic push_sequence(int count, int tone);
        for (int i = 0; i < count; i++) begin
            push_sample(draw_sample(tone), i == count - 1);
        end
    endtask

    // wait until every transaction is taken and every summary has come back
    task automatic settle();
        while (taken_count != queued_count || window_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_register(logic [PADDR_BITS-1:0] addr, logic [31:0] data);
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == LEN_ADDR) begin
            cfg_len = data[8:0];
            clear_run();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                track_sample(s_data);
                taken_count++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (sample_queue.size() != 0) begin
                    s_data   <= sample_queue.pop_front();
                    s_valid  <= 1'b1;
                    send_gap <= send_lazy ? $urandom_range(0, MAX_GAP) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        out_t want;
        int   stall;
        if (!aresetn) begin
            m_ready     <= 1'b0;
            hold_cycles <= 0;
        end else if (m_valid && m_ready) begin
            if (window_results.size() == 0) begin
                $display("%0t: unexpected result sum %0d avg %0d short %0b", $time,
                         $signed(m_data.max_window_sum), $signed(m_data.max_average),
                         m_data.too_short);
                error_count++;
            end else begin
                want = window_results.pop_front();
                if (m_data.max_window_sum !== want.max_window_sum) begin
                    $display("%0t: max_window_sum expected %0d actual %0d", $time,
                             $signed(want.max_window_sum), $signed(m_data.max_window_sum));
                    error_count++;
                end
                if (m_data.max_average !== want.max_average) begin
                    $display("%0t: max_average expected %0d actual %0d", $time,
                             $signed(want.max_average), $signed(m_data.max_average));
                    error_count++;
                end
                if (m_data.too_short !== want.too_short) begin
                    $display("%0t: too_short expected %0b actual %0b", $time,
                             want.too_short, m_data.too_short);
                    error_count++;
                end
            end
            stall = recv_lazy ? $urandom_range(0, MAX_GAP) : 0;
            hold_cycles <= stall;
            m_ready     <= (stall == 0);
        end else if (m_valid && hold_cycles != 0) begin
            // count the stall only while a transaction is actually offered
            hold_cycles <= hold_cycles - 1;
            m_ready     <= (hold_cycles == 1);
        end else begin
            m_ready <= (hold_cycles == 0);
        end
    end

    initial begin
        int unsigned pick;
        int unsigned len_val;
        int unsigned len_eff;
        int unsigned count;
        bit          went_wide;
        cfg_len   = 9'd1;
        went_wide = 1'b0;
        clear_run();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // window of one from reset: extremes and a plain maximum
        send_lazy = 1'b1;
        recv_lazy = 1'b1;
        push_sample(16'sh8000, 1'b1);
        push_sample(16'sh7FFF, 1'b1);
        push_sample(16'sd0, 1'b0);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sd1, 1'b1);
        // zero length acts as one
        set_register(LEN_ADDR, 32'd0);
        push_sample(-16'sd5, 1'b1);
        // too short, then negative windows with a truncated mean
        set_register(LEN_ADDR, 32'd3);
        push_sample(16'sd100, 1'b0);
        push_sample(16'sd200, 1'b1);
        push_sample(-16'sd7, 1'b0);
        push_sample(-16'sd3, 1'b0);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sd5, 1'b1);
        // abandon a sequence by rewriting the length
        push_sample(16'sd1000, 1'b0);
        push_sample(16'sd2000, 1'b0);
        set_register(LEN_ADDR, 32'd2);
        push_sample(16'sd3, 1'b0);
        push_sample(-16'sd4, 1'b1);
        // oversized length saturates to the ring depth
        set_register(LEN_ADDR, 32'hFFFF_FFFF);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh7FFF, 1'b1);
        // writes to the unused register change nothing
        set_register(SPARE_ADDR, 32'd7);
        push_sample(16'sd1, 1'b1);

        while (queued_count < TOTAL_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                len_val = 0;
            end else if (pick == 1 && !went_wide) begin
                len_val = WINDOW_MAX;
            end else if (pick == 2) begin
                len_val = $urandom_range(WINDOW_MAX + 1, 511);
            end else if (pick < 8) begin
                len_val = $urandom_range(9, 40);
            end else begin
                len_val = $urandom_range(1, 8);
            end
            len_eff = (len_val == 0) ? 1 : (len_val > WINDOW_MAX) ? WINDOW_MAX : len_val;
            set_register(LEN_ADDR, ($urandom & ~32'h1FF) | len_val);
            send_lazy = $urandom_range(0, 3) != 0;
            recv_lazy = $urandom_range(0, 3) != 0;
            if (len_eff == WINDOW_MAX) begin
                if (went_wide) begin
                    push_sequence($urandom_range(1, 20), TONE_MIXED);
                end else begin
                    went_wide = 1'b1;
                    push_sequence(WINDOW_MAX + $urandom_range(0, 10), $urandom_range(0, 2));
                end
            end else begin
                repeat ($urandom_range(3, 8)) begin
                    if ($urandom_range(0, 9) == 0 && len_eff > 1) begin
                        count = $urandom_range(1, len_eff - 1);
                    end else begin
                        count = len_eff + $urandom_range(0, 12);
                    end
                    pick = $urandom_range(0, 9);
                    push_sequence(count, pick == 0 ? TONE_HIGH :
                                         pick == 1 ? TONE_LOW : TONE_MIXED);
                end
            end
            // leave an unfinished tail for the next length write to drop
            if ($urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 4)) push_sample(draw_sample(TONE_MIXED), 1'b0);
            end
        end

        settle();
        if (error_count == 0) begin
            $display("** sliding_window_max_average_unit: PASSED **");
        end else begin
            $display("** sliding_window_max_average_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("** sliding_window_max_average_unit: FAILED **");
        $finish;
    end

endmodule

>>> files.f
sv/swma_pkg.sv
sv/swma_ram.sv
sv/swma_window.sv
sv/swma_div.sv
sv/sliding_window_max_average_unit.sv
verif/sliding_window_max_average_unit_test.sv
